// ----- src/spd_pkg.sv -----
package spd_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 24;

  localparam int POS_W  = 24;
  localparam int DIFF_W = 25;
  localparam int CFG_W  = 12;
  // near cars have |d| < 4096, so 13 bits of the difference suffice
  localparam int NEAR_W = 13;
  localparam int FRAC_W = 16;
  localparam int XY_W   = 33;
  localparam int Z_W    = 34;
  localparam int XS_W   = XY_W + 1;
  localparam int GAIN_W = 16;
  localparam logic [GAIN_W-1:0] GAIN_INV = 16'd39797;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  typedef enum logic [1:0] {
    REG_SIDE_MAX   = 2'd0,
    REG_SIDE_MIN   = 2'd1,
    REG_CAR_LENGTH = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    SIDE_NONE  = 2'd0,
    SIDE_LEFT  = 2'd1,
    SIDE_RIGHT = 2'd2
  } side_t;

  typedef struct packed {
    logic signed [POS_W-1:0] own_x;
    logic signed [POS_W-1:0] own_y;
    logic [15:0]             heading;
    logic signed [POS_W-1:0] other_x;
    logic signed [POS_W-1:0] other_y;
    logic                    is_own_car;
    logic                    last_in_frame;
  } in_t;

  typedef struct packed {
    logic [1:0] side;
    logic       frame_end;
  } out_t;

  // sideband that rides along the pipeline
  typedef struct packed {
    logic valid;
    logic near;
    logic last;
  } ctl_t;

  localparam logic [31:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  // atan(2^-i) in 2^-32 turn units
  function automatic logic signed [Z_W-1:0] atan_turn(input int i);
    logic [31:0] v;
    v = ATAN_TURN32[i];
    return $signed({{(Z_W-32){1'b0}}, v});
  endfunction

endpackage

// ----- src/spd_cordic.sv -----
module spd_cordic #(
  parameter int STAGES = spd_pkg::CORDIC_STAGES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  spd_pkg::ctl_t                   ctl_in,
  input  logic signed [spd_pkg::XY_W-1:0] x_in,
  input  logic signed [spd_pkg::XY_W-1:0] y_in,
  input  logic signed [spd_pkg::Z_W-1:0]  z_in,
  output spd_pkg::ctl_t                   ctl_out,
  output logic signed [spd_pkg::XY_W-1:0] x_out,
  output logic signed [spd_pkg::XY_W-1:0] y_out
);
  import spd_pkg::*;

  logic signed [XY_W-1:0] x_r [STAGES];
  logic signed [XY_W-1:0] y_r [STAGES];
  logic signed [Z_W-1:0]  z_r [STAGES];
  ctl_t                   ctl_r [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [XY_W-1:0] x_p, y_p, xsh, ysh, x_nxt, y_nxt;
    logic signed [Z_W-1:0]  z_p, z_nxt;
    ctl_t                   ctl_p;

    if (i == 0) begin : g_first
      assign x_p   = x_in;
      assign y_p   = y_in;
      assign z_p   = z_in;
      assign ctl_p = ctl_in;
    end else begin : g_next
      assign x_p   = x_r[i-1];
      assign y_p   = y_r[i-1];
      assign z_p   = z_r[i-1];
      assign ctl_p = ctl_r[i-1];
    end

    // arithmetic shift is the floor shift
    assign xsh = x_p >>> i;
    assign ysh = y_p >>> i;

    always_comb begin
      if (!z_p[Z_W-1]) begin
        x_nxt = x_p - ysh;
        y_nxt = y_p + xsh;
        z_nxt = z_p - atan_turn(i);
      end else begin
        x_nxt = x_p + ysh;
        y_nxt = y_p - xsh;
        z_nxt = z_p + atan_turn(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[i].valid <= 1'b0;
      end else begin
        ctl_r[i].valid <= ctl_p.valid;
      end
      ctl_r[i].near <= ctl_p.near;
      ctl_r[i].last <= ctl_p.last;
      x_r[i]        <= x_nxt;
      y_r[i]        <= y_nxt;
      z_r[i]        <= z_nxt;
    end
  end

  assign ctl_out = ctl_r[STAGES-1];
  assign x_out   = x_r[STAGES-1];
  assign y_out   = y_r[STAGES-1];

endmodule

// ----- src/side_proximity_detector_top.sv -----
// Channel  Ports                          Handshake
// input    start, busy, in_item           beat taken when start && !busy
// result   out_valid, out_item            one-cycle strobe, no back-pressure
// config   psel/penable/pwrite/paddr/...  APB, pready tied high
//
// One beat per cycle; busy stays low. Registered steps, in order:
// difference, box check and fold, one CORDIC micro-rotation per stage,
// gain multiply, then window compare into the output register.
// Synchronous reset clears the valid bits and restores the window registers.
// Every accepted beat gives exactly one result beat.
module side_proximity_detector_top #(
  parameter int CORDIC_STAGES = spd_pkg::CORDIC_STAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  spd_pkg::in_t                 in_item,
  output logic                         out_valid,
  output spd_pkg::out_t                out_item,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spd_pkg::APB_AW-1:0]   paddr,
  input  logic [spd_pkg::APB_DW-1:0]   pwdata,
  output logic [spd_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import spd_pkg::*;

  // configuration
  logic [CFG_W-1:0] side_max_r, side_min_r, car_length_r;
  reg_idx_t         reg_idx;
  logic             cfg_wr;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_max_r   <= CFG_W'(448);
      side_min_r   <= CFG_W'(64);
      car_length_r <= CFG_W'(320);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SIDE_MAX:   side_max_r   <= pwdata[CFG_W-1:0];
        REG_SIDE_MIN:   side_min_r   <= pwdata[CFG_W-1:0];
        REG_CAR_LENGTH: car_length_r <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SIDE_MAX:   prdata = {{(APB_DW-CFG_W){1'b0}}, side_max_r};
      REG_SIDE_MIN:   prdata = {{(APB_DW-CFG_W){1'b0}}, side_min_r};
      REG_CAR_LENGTH: prdata = {{(APB_DW-CFG_W){1'b0}}, car_length_r};
      default:        prdata = '0;
    endcase
  end

  // stage 0: differences
  logic                     v0_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r;
  logic [15:0]              head_r;
  logic                     own_r, last0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
    end
    dx_r    <= DIFF_W'(in_item.own_x) - DIFF_W'(in_item.other_x);
    dy_r    <= DIFF_W'(in_item.own_y) - DIFF_W'(in_item.other_y);
    head_r  <= in_item.heading;
    own_r   <= in_item.is_own_car;
    last0_r <= in_item.last_in_frame;
  end

  // stage 1: box check and quadrant fold
  logic [DIFF_W-1:0]      dxa, dya, box;
  logic signed [16:0]     ang;
  logic                   fold;
  logic signed [XY_W-1:0] xq, yq;
  ctl_t                   ctl1_nxt, ctl1_r;
  logic signed [XY_W-1:0] x1_r, y1_r;
  logic signed [Z_W-1:0]  z1_r, z1_nxt;

  always_comb begin
    dxa = dx_r[DIFF_W-1] ? DIFF_W'(-dx_r) : dx_r;
    dya = dy_r[DIFF_W-1] ? DIFF_W'(-dy_r) : dy_r;
    box = (car_length_r > side_max_r) ? DIFF_W'(car_length_r) : DIFF_W'(side_max_r);

    ang  = {head_r[15], head_r};
    fold = 1'b0;
    if (ang > 17'sd16384) begin
      ang  = ang - 17'sd32768;
      fold = 1'b1;
    end else if (ang < -17'sd16384) begin
      ang  = ang + 17'sd32768;
      fold = 1'b1;
    end
    z1_nxt = {{(Z_W-17-FRAC_W){ang[16]}}, ang, {FRAC_W{1'b0}}};

    xq = {{(XY_W-NEAR_W-FRAC_W){dx_r[NEAR_W-1]}}, dx_r[NEAR_W-1:0], {FRAC_W{1'b0}}};
    yq = {{(XY_W-NEAR_W-FRAC_W){dy_r[NEAR_W-1]}}, dy_r[NEAR_W-1:0], {FRAC_W{1'b0}}};

    ctl1_nxt.valid = v0_r;
    ctl1_nxt.near  = !own_r && (dxa < box) && (dya < box);
    ctl1_nxt.last  = last0_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r.valid <= 1'b0;
    end else begin
      ctl1_r.valid <= ctl1_nxt.valid;
    end
    ctl1_r.near <= ctl1_nxt.near;
    ctl1_r.last <= ctl1_nxt.last;
    x1_r        <= fold ? -xq : xq;
    y1_r        <= fold ? -yq : yq;
    z1_r        <= z1_nxt;
  end

  // rotation
  ctl_t                   ctl_c;
  logic signed [XY_W-1:0] xc, yc;

  spd_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (ctl1_r),
    .x_in    (x1_r),
    .y_in    (y1_r),
    .z_in    (z1_r),
    .ctl_out (ctl_c),
    .x_out   (xc),
    .y_out   (yc)
  );

  // gain removal
  logic signed [XY_W+GAIN_W:0] px, py;
  logic signed [XS_W-1:0]      xs_r, ys_r;
  ctl_t                        ctlm_r;

  assign px = xc * $signed({1'b0, GAIN_INV});
  assign py = yc * $signed({1'b0, GAIN_INV});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctlm_r.valid <= 1'b0;
    end else begin
      ctlm_r.valid <= ctl_c.valid;
    end
    ctlm_r.near <= ctl_c.near;
    ctlm_r.last <= ctl_c.last;
    xs_r        <= px[XY_W+GAIN_W:FRAC_W];
    ys_r        <= py[XY_W+GAIN_W:FRAC_W];
  end

  // window compare
  logic [XS_W-1:0] xa, ya, lim_max, lim_min, lim_len;
  side_t           side_nxt;

  always_comb begin
    xa      = xs_r[XS_W-1] ? XS_W'(-xs_r) : xs_r;
    ya      = ys_r[XS_W-1] ? XS_W'(-ys_r) : ys_r;
    lim_max = {{(XS_W-CFG_W-FRAC_W){1'b0}}, side_max_r, {FRAC_W{1'b0}}};
    lim_min = {{(XS_W-CFG_W-FRAC_W){1'b0}}, side_min_r, {FRAC_W{1'b0}}};
    lim_len = {{(XS_W-CFG_W-FRAC_W){1'b0}}, car_length_r, {FRAC_W{1'b0}}};
    side_nxt = SIDE_NONE;
    if (ctlm_r.near && (xa < lim_max) && (xa > lim_min) && (ya < lim_len)) begin
      side_nxt = xs_r[XS_W-1] ? SIDE_LEFT : SIDE_RIGHT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ctlm_r.valid;
    end
    out_item.side      <= side_nxt;
    out_item.frame_end <= ctlm_r.last;
  end

endmodule

// ----- src/spd_checker.sv -----
module spd_checker #(
  parameter int STAGES = spd_pkg::CORDIC_STAGES_DEF
) (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input spd_pkg::in_t  in_item,
  input logic          out_valid,
  input spd_pkg::out_t out_item
);
  import spd_pkg::*;

  localparam int LAT = STAGES + 4;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted beat gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without an accepted beat");

  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.frame_end == $past(in_item.last_in_frame, LAT)))
    else $error("frame_end does not follow last_in_frame");

  a_own_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_item.is_own_car, LAT)) |-> (out_item.side == SIDE_NONE))
    else $error("own car reported beside");

endmodule

bind side_proximity_detector_top spd_checker #(
  .STAGES (CORDIC_STAGES)
) u_spd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// ----- dv/tb_side_proximity_detector_top.sv -----
module tb_side_proximity_detector_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spd_pkg::*;

  localparam int NSTAGES   = 16;
  localparam int SETTLE_CY = NSTAGES + 8;

  // atan(2^-i) in 2^-32 turn
  localparam longint ROT_ANGLE [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C, 64'h000028BE, 64'h0000145F,
    64'h00000A2F, 64'h00000517, 64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  in_t               in_item = '0;
  logic              out_valid;
  out_t              out_item;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // window registers as the block should hold them
  longint lat_max = 448;
  longint lat_min = 64;
  longint lon_len = 320;

  out_t side_reports_due[$];
  int   mismatch_count = 0;

  side_proximity_detector_top #(.CORDIC_STAGES(NSTAGES)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint box_size();
    return (lon_len > lat_max) ? lon_len : lat_max;
  endfunction

  function automatic out_t classify_pair(in_t it);
    out_t   r;
    longint dx, dy, x, y, z, ang, xsh, ysh, xs, ys;
    int     i;
    r.side      = SIDE_NONE;
    r.frame_end = it.last_in_frame;
    dx = longint'($signed(it.own_x)) - longint'($signed(it.other_x));
    dy = longint'($signed(it.own_y)) - longint'($signed(it.other_y));
    if (!it.is_own_car && mag(dx) < box_size() && mag(dy) < box_size()) begin
      x   = dx * 65536;
      y   = dy * 65536;
      ang = longint'(it.heading);
      if (ang >= 32768) ang -= 65536;
      // fold to +-quarter turn, half turn flips the vector
      if (ang > 16384) begin
        x = -x; y = -y; ang -= 32768;
      end else if (ang < -16384) begin
        x = -x; y = -y; ang += 32768;
      end
      z = ang * 65536;
      for (i = 0; i < NSTAGES && i < 24; i++) begin
        xsh = x >>> i;
        ysh = y >>> i;
        if (z >= 0) begin
          x = x - ysh; y = y + xsh; z -= ROT_ANGLE[i];
        end else begin
          x = x + ysh; y = y - xsh; z += ROT_ANGLE[i];
        end
      end
      xs = (x * 39797) >>> 16;
      ys = (y * 39797) >>> 16;
      if (mag(xs) < lat_max * 65536 && mag(xs) > lat_min * 65536 &&
          mag(ys) < lon_len * 65536)
        r.side = (xs < 0) ? SIDE_LEFT : SIDE_RIGHT;
    end
    return r;
  endfunction

  function automatic in_t pair_of(longint ox, longint oy, int hd, longint px, longint py,
                                  bit own, bit last);
    in_t it;
    it.own_x         = ox[POS_W-1:0];
    it.own_y         = oy[POS_W-1:0];
    it.heading       = hd[15:0];
    it.other_x       = px[POS_W-1:0];
    it.other_y       = py[POS_W-1:0];
    it.is_own_car    = own;
    it.last_in_frame = last;
    return it;
  endfunction

  // mostly neighbours around the box edge, some own entries, some far cars
  function automatic in_t random_pair();
    in_t    it;
    int     sel, span;
    longint dx, dy;
    logic [POS_W-1:0] ox, oy;
    sel  = $urandom_range(0, 99);
    span = int'(box_size()) + 16;
    ox   = POS_W'($urandom);
    oy   = POS_W'($urandom);
    dx   = longint'(int'($urandom_range(0, 2 * span)) - span);
    dy   = longint'(int'($urandom_range(0, 2 * span)) - span);
    it.own_x         = ox;
    it.own_y         = oy;
    it.heading       = 16'($urandom_range(0, 65535));
    it.is_own_car    = (sel >= 78 && sel < 88);
    it.last_in_frame = 1'($urandom_range(0, 1));
    if (sel < 88) begin
      it.other_x = ox - dx[POS_W-1:0];
      it.other_y = oy - dy[POS_W-1:0];
    end else begin
      it.other_x = POS_W'($urandom);
      it.other_y = POS_W'($urandom);
    end
    return it;
  endfunction

  task automatic send_pair(in_t it);
    in_item <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    side_reports_due.push_back(classify_pair(it));
  endtask

  task automatic hold_off(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (side_reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CY) @(posedge clk);
  endtask

  task automatic cfg_write(logic [APB_AW-1:0] addr, logic [11:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {20'($urandom_range(0, 1048575)), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (addr[3:2])
      REG_SIDE_MAX:   lat_max = longint'(val);
      REG_SIDE_MIN:   lat_min = longint'(val);
      REG_CAR_LENGTH: lon_len = longint'(val);
      default: ;
    endcase
  endtask

  task automatic set_window(int smax, int smin, int clen);
    cfg_write({REG_SIDE_MAX, 2'b00}, smax[11:0]);
    cfg_write({REG_SIDE_MIN, 2'b00}, smin[11:0]);
    cfg_write({REG_CAR_LENGTH, 2'b00}, clen[11:0]);
  endtask

  // bursts of random length, gaps of random length, sometimes none
  task automatic burst_traffic(int n);
    int sent, blen;
    sent = 0;
    while (sent < n) begin
      blen = $urandom_range(1, 40);
      while (blen > 0 && sent < n) begin
        send_pair(random_pair());
        blen--;
        sent++;
      end
      if ($urandom_range(0, 2) != 0) hold_off($urandom_range(1, 6));
    end
    settle();
  endtask

  task automatic test_directed_cases();
    in_t dir_q[$];
    dir_q.push_back(pair_of(1000, 1000, 0, 800, 1000, 1, 0));     // own entry
    dir_q.push_back(pair_of(1000, 1000, 0, 800, 1000, 0, 0));
    dir_q.push_back(pair_of(1000, 1000, 0, 1200, 1000, 0, 1));
    dir_q.push_back(pair_of(0, 0, 0, -448, 0, 0, 0));              // on box edge
    dir_q.push_back(pair_of(0, 0, 0, 0, 448, 0, 0));
    dir_q.push_back(pair_of(0, 0, 0, -447, -319, 0, 1));
    dir_q.push_back(pair_of(0, 0, 0, -64, 0, 0, 0));               // lateral = side_min
    dir_q.push_back(pair_of(5, -5, 0, 5, -5, 0, 0));               // same spot
    dir_q.push_back(pair_of(0, 0, 16384, 0, -200, 0, 0));
    dir_q.push_back(pair_of(0, 0, 16385, 0, -200, 0, 1));
    dir_q.push_back(pair_of(0, 0, 32768, -200, 0, 0, 0));
    dir_q.push_back(pair_of(0, 0, 49151, 0, 200, 0, 0));
    dir_q.push_back(pair_of(0, 0, 49152, 0, 200, 0, 0));
    dir_q.push_back(pair_of(0, 0, 65535, -300, 100, 0, 1));
    dir_q.push_back(pair_of(0, 0, 1, 300, -100, 0, 0));
    // full-range positions, difference needs the 25th bit
    dir_q.push_back(pair_of(8388607, -8388608, 8192, -8388608, 8388607, 0, 0));
    dir_q.push_back(pair_of(-8388608, -8388608, 24576, -8388408, -8388508, 0, 1));
    dir_q.push_back(pair_of(8388607, 8388607, 40960, 8388307, 8388557, 0, 0));
    dir_q.push_back(pair_of(-8388608, 8388607, 57344, -8388608, 8388607, 1, 1));
    foreach (dir_q[k]) begin
      send_pair(dir_q[k]);
      if (k % 5 == 4) hold_off($urandom_range(1, 3));
    end
    settle();
  endtask

  task automatic test_reset_window();
    burst_traffic(300);
  endtask

  task automatic test_window_extremes();
    set_window(0, 0, 0);
    burst_traffic(150);
    set_window(4095, 4095, 4095);
    burst_traffic(150);
    set_window(4095, 0, 4095);
    burst_traffic(150);
    set_window(0, 4095, 4095);
    burst_traffic(100);
    set_window(4095, 0, 0);
    burst_traffic(100);
  endtask

  task automatic test_random_windows();
    repeat (4) begin
      set_window($urandom_range(0, 4095), $urandom_range(0, 1023), $urandom_range(0, 4095));
      burst_traffic(200);
    end
  endtask

  // index 3 is not a register, the window must stay as it was
  task automatic test_unused_index();
    set_window(600, 32, 500);
    cfg_write({2'd3, 2'b00}, 12'($urandom_range(0, 4095)));
    burst_traffic(200);
  endtask

  always @(posedge clk) begin
    out_t due;
    if (rst_n && out_valid) begin
      if (side_reports_due.size() == 0) begin
        $error("result beat with none pending: side=%0d frame_end=%0b",
               out_item.side, out_item.frame_end);
        mismatch_count++;
      end else begin
        due = side_reports_due.pop_front();
        if (out_item.side !== due.side) begin
          $error("side: expected %0d, got %0d", due.side, out_item.side);
          mismatch_count++;
        end
        if (out_item.frame_end !== due.frame_end) begin
          $error("frame_end: expected %0b, got %0b", due.frame_end, out_item.frame_end);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_directed_cases();
    test_reset_window();
    test_window_extremes();
    test_random_windows();
    test_unused_index();
    settle();
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
